// ===== sv/run_and_pair_code_decoder_defines.svh =====
// ----------------------------------------------------------------------------
// Run and pair code decoder: assertion macros
// Clocked assertion wrappers, empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef RUN_AND_PAIR_CODE_DECODER_DEFINES_SVH
`define RUN_AND_PAIR_CODE_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
// Check that prop holds at every rising clock edge outside reset.
`define RPCD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that cond never holds at a rising clock edge outside reset.
`define RPCD_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define RPCD_ASSERT(label, clk, rst_n, prop, msg)
`define RPCD_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

// ===== sv/rpcd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Run and pair code decoder package
// Shared widths, codes and the decode request type.
// ----------------------------------------------------------------------------
package rpcd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CFG_IDX_W = 2;

  typedef logic [BYTE_W-1:0] byte_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RUN_LIMIT  = 2'd0,
    CFG_PAIR_COUNT = 2'd1,
    CFG_LIT_OFFSET = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    MODE_LOAD   = 1'b0,
    MODE_DECODE = 1'b1
  } mode_e;

  localparam byte_t PAIR_RUN_LEN    = 8'd2;
  localparam byte_t LITERAL_RUN_LEN = 8'd1;

  // Result request from the front end to the result stage.
  typedef struct packed {
    logic  valid;  // item yields a result
    logic  pair;   // value comes from the pair table
    byte_t value;  // final value unless pair
    byte_t len;    // run length
  } req_t;

endpackage

// ===== sv/rpcd_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Run and pair code decoder channels
// Input item and result item channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface rpcd_in_if;
  logic                 valid;
  logic                 ready;
  logic                 mode;
  rpcd_pkg::byte_t      table_index;
  rpcd_pkg::byte_t      data_byte;

  modport source (output valid, mode, table_index, data_byte, input ready);
  modport sink   (input valid, mode, table_index, data_byte, output ready);
endinterface

interface rpcd_out_if;
  logic                 valid;
  logic                 ready;
  rpcd_pkg::byte_t      out_value;
  rpcd_pkg::byte_t      run_length;

  modport source (output valid, out_value, run_length, input ready);
  modport sink   (input valid, out_value, run_length, output ready);
endinterface

// ===== sv/rpcd_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Run and pair code decoder pair table
// Single-port-write, single-port-read memory, registered read, per-entry
// valid bits so that entries never written read as zero.
// ----------------------------------------------------------------------------
module rpcd_table #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  rpcd_pkg::byte_t          wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output rpcd_pkg::byte_t          rdata_o
);

  rpcd_pkg::byte_t mem_q [DEPTH];
  logic [DEPTH-1:0] vld_q;
  rpcd_pkg::byte_t  rd_q;
  logic             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_q <= mem_q[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rd_vld_q <= vld_q[raddr_i];
      end
    end
  end

  assign rdata_o = rd_vld_q ? rd_q : '0;

endmodule

// ===== sv/rpcd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Run and pair code decoder front end
// Classify a stream byte, track the armed run, form the table read address.
// ----------------------------------------------------------------------------
module rpcd_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic            mode_i,
  input  rpcd_pkg::byte_t code_i,
  input  rpcd_pkg::byte_t run_limit_i,
  input  rpcd_pkg::byte_t pair_count_i,
  input  logic            lit_offset_i,
  output rpcd_pkg::byte_t raddr_o,
  output rpcd_pkg::req_t  req_o
);

  logic            armed_q, armed_d;
  rpcd_pkg::byte_t pend_len_q, pend_len_d;
  rpcd_pkg::byte_t pair_bound;

  assign pair_bound = run_limit_i + pair_count_i;
  assign raddr_o    = code_i - run_limit_i;

  always_comb begin
    armed_d    = armed_q;
    pend_len_d = pend_len_q;
    req_o      = '0;
    if (mode_i == rpcd_pkg::MODE_DECODE) begin
      if (armed_q) begin
        // byte after a run code is the run value whatever it is
        armed_d     = 1'b0;
        req_o.valid = 1'b1;
        req_o.value = code_i - 8'd1;
        req_o.len   = pend_len_q;
      end else if (code_i < run_limit_i) begin
        armed_d    = 1'b1;
        pend_len_d = code_i + 8'd1;
      end else if (code_i < pair_bound) begin
        req_o.valid = 1'b1;
        req_o.pair  = 1'b1;
        req_o.len   = rpcd_pkg::PAIR_RUN_LEN;
      end else begin
        req_o.valid = 1'b1;
        req_o.value = code_i - {7'd0, lit_offset_i};
        req_o.len   = rpcd_pkg::LITERAL_RUN_LEN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q    <= 1'b0;
      pend_len_q <= '0;
    end else if (accept_i) begin
      armed_q    <= armed_d;
      pend_len_q <= pend_len_d;
    end
  end

endmodule

// ===== sv/run_and_pair_code_decoder.sv =====
// Pipeline: an item is registered in stage one (with the pair table read), then in the output register.
// Throughput: one item per cycle unless the output stalls; the pair table read in the
// cycle after the transfer is the only memory access on the path, one per item.
// Reset: control, run state and configuration registers clear at once; table valid bits
// clear at once so the whole pair table reads as zero; no clearing pass.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Run and pair code decoder
// Decodes run, pair-dictionary and literal codes of a compressed byte stream
// into (value, length) results, and loads the pair table.
// ----------------------------------------------------------------------------
`include "run_and_pair_code_decoder_defines.svh"

module run_and_pair_code_decoder #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [rpcd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  rpcd_pkg::byte_t            cfg_data_i,
  rpcd_in_if.sink                    in_i,
  rpcd_out_if.source                 out_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  // Configuration registers.
  rpcd_pkg::byte_t run_limit_q, pair_count_q;
  logic            lit_offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_limit_q  <= '0;
      pair_count_q <= '0;
      lit_offset_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rpcd_pkg::CFG_RUN_LIMIT:  run_limit_q  <= cfg_data_i;
        rpcd_pkg::CFG_PAIR_COUNT: pair_count_q <= cfg_data_i;
        rpcd_pkg::CFG_LIT_OFFSET: lit_offset_q <= cfg_data_i[0];
        default: ;  // unknown index: drop the write
      endcase
    end
  end

  // Handshake and stage control.
  logic in_xfer, s1_adv, s1_valid_q, out_valid_q;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_xfer    = in_i.valid && in_i.ready;

  // Front end: classify the byte and keep the armed run.
  rpcd_pkg::byte_t raddr;
  rpcd_pkg::req_t  req;

  rpcd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (in_xfer),
    .mode_i       (in_i.mode),
    .code_i       (in_i.data_byte),
    .run_limit_i  (run_limit_q),
    .pair_count_i (pair_count_q),
    .lit_offset_i (lit_offset_q),
    .raddr_o      (raddr),
    .req_o        (req)
  );

  // Pair table: write on a load transfer, read on every transfer. A write
  // lands before any later read of the same entry, so no forwarding is
  // needed. The read register holds while stage one stalls.
  logic            tbl_we;
  rpcd_pkg::byte_t tbl_rdata;

  assign tbl_we = in_xfer && (in_i.mode == rpcd_pkg::MODE_LOAD);

  rpcd_table #(
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (tbl_we),
    .waddr_i (in_i.table_index[AW-1:0]),
    .wdata_i (in_i.data_byte),
    .re_i    (in_xfer),
    .raddr_i (raddr[AW-1:0]),
    .rdata_o (tbl_rdata)
  );

  // Stage one: hold the request while the table read completes.
  logic            s1_pair_q;
  rpcd_pkg::byte_t s1_value_q, s1_len_q, s1_value;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= req.valid;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_pair_q  <= req.pair;
      s1_value_q <= req.value;
      s1_len_q   <= req.len;
    end
  end

  // Pair entries are stored one above the emitted value.
  assign s1_value = s1_pair_q ? (tbl_rdata - 8'd1) : s1_value_q;

  // Output register: parts the result side from the table read.
  rpcd_pkg::byte_t out_value_q, out_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_value_q <= s1_value;
      out_len_q   <= s1_len_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.out_value  = out_value_q;
  assign out_o.run_length = out_len_q;

  // A run length of zero means a run code was taken at or above the limit.
  `RPCD_ASSERT(a_len_nonzero, clk_i, rst_ni, out_valid_q |-> (out_len_q != 8'd0), "zero run length")
  // Back pressure on the input only comes from an occupied stage one.
  `RPCD_ASSERT_NEVER(a_ready_low_empty, clk_i, rst_ni, !in_i.ready && !s1_valid_q, "input stalled with stage one empty")
  // A stalled stage one keeps its item.
  `RPCD_ASSERT(a_s1_hold, clk_i, rst_ni, (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_value_q) && $stable(s1_len_q)), "stage one lost a stalled item")

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Run and pair code decoder testbench
// Drives table loads and stream bytes into the decoder under several register
// settings and idle patterns, predicts every (value, length) result and
// compares each result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned CYCLE_LIMIT   = 300000;
  localparam int unsigned DRAIN_CYCLES  = 8;
  localparam int unsigned ITEMS_PER_SEG = 220;
  localparam int unsigned NUM_SEGS      = 8;
  localparam int unsigned MAX_PRINTED   = 40;
  // Index outside the register map; the decoder must ignore writes to it.
  localparam logic [rpcd_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

  typedef struct packed {
    rpcd_pkg::byte_t value;
    rpcd_pkg::byte_t len;
  } decoded_run_t;

  // Tracks the decoder state and the queue of runs still owed by the block.
  class run_decode_scoreboard;
    rpcd_pkg::byte_t pair_tbl [256];
    logic            run_armed;
    rpcd_pkg::byte_t armed_len;
    rpcd_pkg::byte_t run_limit;
    rpcd_pkg::byte_t pair_count;
    logic            lit_offset;
    decoded_run_t    expected_runs [$];

    function new();
      foreach (pair_tbl[i]) pair_tbl[i] = '0;
      run_armed  = 1'b0;
      armed_len  = '0;
      run_limit  = '0;
      pair_count = '0;
      lit_offset = 1'b0;
    endfunction

    function void write_reg(logic [rpcd_pkg::CFG_IDX_W-1:0] idx, rpcd_pkg::byte_t val);
      case (idx)
        rpcd_pkg::CFG_RUN_LIMIT:  run_limit  = val;
        rpcd_pkg::CFG_PAIR_COUNT: pair_count = val;
        rpcd_pkg::CFG_LIT_OFFSET: lit_offset = val[0];
        default: ;
      endcase
    endfunction

    // Append one owed run at the tail of the queue.
    function void owe_run(decoded_run_t r);
      expected_runs.insert(expected_runs.size(), r);
    endfunction

    // Predict the result, if any, of one accepted input transfer.
    function void note_stream_item(rpcd_pkg::mode_e m, rpcd_pkg::byte_t idx,
                                   rpcd_pkg::byte_t code);
      rpcd_pkg::byte_t bound;
      decoded_run_t    run;
      if (m == rpcd_pkg::MODE_LOAD) begin
        pair_tbl[idx] = code;
        return;
      end
      if (run_armed) begin
        run_armed = 1'b0;
        run.value = code - 8'd1;
        run.len   = armed_len;
        owe_run(run);
        return;
      end
      bound = run_limit + pair_count;
      if (code < run_limit) begin
        run_armed = 1'b1;
        armed_len = code + 8'd1;
      end else if (code < bound) begin
        run.value = pair_tbl[rpcd_pkg::byte_t'(code - run_limit)] - 8'd1;
        run.len   = rpcd_pkg::PAIR_RUN_LEN;
        owe_run(run);
      end else begin
        run.value = code - rpcd_pkg::byte_t'(lit_offset);
        run.len   = rpcd_pkg::LITERAL_RUN_LEN;
        owe_run(run);
      end
    endfunction

    function bit check_run(rpcd_pkg::byte_t v, rpcd_pkg::byte_t l, output string why);
      decoded_run_t exp_run;
      why = "";
      if (expected_runs.size() == 0) begin
        why = $sformatf("unexpected run value %02h length %0d", v, l);
        return 1'b0;
      end
      exp_run = expected_runs.pop_front();
      if (v !== exp_run.value)
        why = $sformatf("value %02h, want %02h; ", v, exp_run.value);
      if (l !== exp_run.len)
        why = {why, $sformatf("length %0d, want %0d", l, exp_run.len)};
      return why == "";
    endfunction

    function int unsigned outstanding();
      return expected_runs.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [rpcd_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  rpcd_pkg::byte_t cfg_data_i;

  rpcd_in_if  in_ch ();
  rpcd_out_if out_ch ();

  run_decode_scoreboard decode_sb = new();

  int unsigned cycle_count    = 0;
  int unsigned mismatch_count = 0;
  int unsigned src_idle_pct   = 0;
  int unsigned snk_stall_pct  = 0;

  // Current register copies, used to steer random codes into each class.
  rpcd_pkg::byte_t cur_run_limit  = '0;
  rpcd_pkg::byte_t cur_pair_count = '0;

  run_and_pair_code_decoder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Hard stop in case the block hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED)
      $display("MISMATCH cycle %0d: %s", cycle_count, what);
  endtask

  // Result sink: stall at the rate of the current phase.
  always @(posedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // Check every result transfer against the oldest prediction.
  always @(posedge clk_i) begin
    string why;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (!decode_sb.check_run(out_ch.out_value, out_ch.run_length, why))
        report_mismatch(why);
    end
  end

  // Present one item, hold it until the transfer, then update the prediction.
  // Valid stays high on return so back-to-back items need no extra edge.
  task automatic send_item(input rpcd_pkg::mode_e m, input rpcd_pkg::byte_t idx,
                           input rpcd_pkg::byte_t code);
    if ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= m;
    in_ch.table_index <= idx;
    in_ch.data_byte   <= code;
    do @(posedge clk_i); while (!in_ch.ready);
    decode_sb.note_stream_item(m, idx, code);
  endtask

  // Drop valid, wait for every owed result, then let in-flight items settle.
  task automatic drain_outstanding();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (decode_sb.outstanding() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [rpcd_pkg::CFG_IDX_W-1:0] idx,
                           input rpcd_pkg::byte_t val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    decode_sb.write_reg(idx, val);
  endtask

  task automatic set_config(input rpcd_pkg::byte_t run_limit,
                            input rpcd_pkg::byte_t pair_count,
                            input rpcd_pkg::byte_t lit_data);
    drain_outstanding();
    write_cfg(rpcd_pkg::CFG_RUN_LIMIT, run_limit);
    write_cfg(rpcd_pkg::CFG_PAIR_COUNT, pair_count);
    write_cfg(rpcd_pkg::CFG_LIT_OFFSET, lit_data);
    cur_run_limit  = run_limit;
    cur_pair_count = pair_count;
  endtask

  // Codes aimed at the run and pair ranges, some table loads, and some
  // raw bytes as noise.
  task automatic send_random_item();
    rpcd_pkg::byte_t bound;
    int unsigned     pick;
    rpcd_pkg::byte_t code;
    rpcd_pkg::byte_t idx;
    idx   = rpcd_pkg::byte_t'($urandom_range(255));
    code  = rpcd_pkg::byte_t'($urandom_range(255));
    bound = cur_run_limit + cur_pair_count;
    if ($urandom_range(99) < 12) begin
      send_item(rpcd_pkg::MODE_LOAD, idx, code);
    end else begin
      pick = $urandom_range(3);
      if (pick == 0 && cur_run_limit > 8'd0)
        code = rpcd_pkg::byte_t'($urandom_range(cur_run_limit - 8'd1, 0));
      else if (pick == 1 && bound > cur_run_limit)
        code = rpcd_pkg::byte_t'($urandom_range(bound - 8'd1, cur_run_limit));
      send_item(rpcd_pkg::MODE_DECODE, idx, code);
    end
  endtask

  initial begin
    rpcd_pkg::byte_t seg_limit [NUM_SEGS];
    rpcd_pkg::byte_t seg_pairs [NUM_SEGS];
    rpcd_pkg::byte_t seg_lit   [NUM_SEGS];

    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = '0;
    cfg_data_i        = '0;
    in_ch.valid       = 1'b0;
    in_ch.mode        = rpcd_pkg::MODE_LOAD;
    in_ch.table_index = '0;
    in_ch.data_byte   = '0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: a write to the unmapped index must change nothing.
    write_cfg(CFG_IDX_SPARE, 8'hFF);
    set_config(8'd16, 8'd16, 8'h01);

    // Pair table edges, including an entry of zero that wraps on the minus one.
    send_item(rpcd_pkg::MODE_LOAD, 8'd0, 8'h00);
    send_item(rpcd_pkg::MODE_LOAD, 8'd15, 8'hFF);
    send_item(rpcd_pkg::MODE_LOAD, 8'd255, 8'h80);
    send_item(rpcd_pkg::MODE_LOAD, 8'd1, 8'h7F);
    // Literals, the first code above the pair range, and pair codes.
    send_item(rpcd_pkg::MODE_DECODE, 8'hFF, 8'd255);
    send_item(rpcd_pkg::MODE_DECODE, 8'h00, 8'd32);
    send_item(rpcd_pkg::MODE_DECODE, 8'h00, 8'd16);
    send_item(rpcd_pkg::MODE_DECODE, 8'h00, 8'd31);
    send_item(rpcd_pkg::MODE_DECODE, 8'h00, 8'd17);
    // Shortest run with a zero value byte.
    send_item(rpcd_pkg::MODE_DECODE, 8'h00, 8'd0);
    send_item(rpcd_pkg::MODE_DECODE, 8'h00, 8'd0);
    // A load in the middle of an armed run leaves the run pending, and the
    // following byte is the run value even though it is itself a run code.
    send_item(rpcd_pkg::MODE_DECODE, 8'h00, 8'd15);
    send_item(rpcd_pkg::MODE_LOAD, 8'd2, 8'h33);
    send_item(rpcd_pkg::MODE_DECODE, 8'h00, 8'd3);

    // Longest run, and the top code as a literal with no offset.
    set_config(8'd255, 8'd0, 8'h00);
    send_item(rpcd_pkg::MODE_DECODE, 8'h00, 8'd254);
    send_item(rpcd_pkg::MODE_DECODE, 8'h00, 8'd255);
    send_item(rpcd_pkg::MODE_DECODE, 8'h00, 8'd255);

    // Wrapped pair bound below the run limit: no pair codes at all.
    set_config(8'd200, 8'd100, 8'h01);
    send_item(rpcd_pkg::MODE_DECODE, 8'h00, 8'd220);
    send_item(rpcd_pkg::MODE_DECODE, 8'h00, 8'd30);
    send_item(rpcd_pkg::MODE_DECODE, 8'h00, 8'd5);

    // No run codes, nearly all pair codes; entry 254 was never loaded.
    set_config(8'd0, 8'd255, 8'h00);
    send_item(rpcd_pkg::MODE_DECODE, 8'h00, 8'd254);
    send_item(rpcd_pkg::MODE_DECODE, 8'h00, 8'd255);
    send_item(rpcd_pkg::MODE_DECODE, 8'h00, 8'd0);

    // Random part: one register setting per segment, idle pattern rotating.
    seg_limit = '{8'd0, 8'd255, 8'd0, 8'd128, 8'd200, 8'd16, 8'd0, 8'd64};
    seg_pairs = '{8'd0, 8'd0, 8'd255, 8'd128, 8'd100, 8'd32, 8'd0, 8'd64};
    seg_lit   = '{8'h00, 8'h01, 8'hFE, 8'hFF, 8'h00, 8'h01, 8'h00, 8'h01};
    seg_limit[6] = rpcd_pkg::byte_t'($urandom_range(255));
    seg_pairs[6] = rpcd_pkg::byte_t'($urandom_range(255));
    seg_lit[6]   = rpcd_pkg::byte_t'($urandom_range(255));

    for (int unsigned seg = 0; seg < NUM_SEGS; seg++) begin
      set_config(seg_limit[seg], seg_pairs[seg], seg_lit[seg]);
      case (seg % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 76; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 76; end
        default: begin src_idle_pct = 24; snk_stall_pct = 24; end
      endcase
      for (int unsigned n = 0; n < ITEMS_PER_SEG; n++)
        send_random_item();
    end

    drain_outstanding();
    if (decode_sb.outstanding() != 0)
      report_mismatch($sformatf("%0d runs never arrived", decode_sb.outstanding()));

    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
